// ===== sv/central_difference_gradient_unit_macros.svh =====
// Assertion macros for the central difference gradient unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH

// same-cycle implication
`define CDG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cdg_pkg.sv =====
// Shared types and constants of the central difference gradient unit.
// No dependencies; imported by every module of the block except cdg_ram.
package cdg_pkg;

   localparam int PIXEL_W            = 8;
   localparam int GRAD_W             = 10;
   localparam int CSR_DATA_W         = 11;
   localparam int CSR_INDEX_W        = 2;
   localparam int IMAGE_WIDTH_RESET  = 640;
   localparam int IMAGE_HEIGHT_RESET = 480;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_FLUSH = 1'b1
   } cdg_action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } cdg_csr_type;

   typedef logic signed [GRAD_W-1:0] cdg_grad_type;

   // position and kind of the word accepted this cycle
   typedef struct packed {
      logic active;      // word changes state (not an ignored pixel or flush)
      logic pix_write;   // pixel word stored into the current line
      logic has_result;  // word releases a result
      logic is_drain;    // flush word draining the final row
      logic first_col;
      logic last_col;
      logic w_one;       // frame one pixel wide
      logic row_one;     // pixel belongs to the second row
      logic h_one;       // frame one row high
   } cdg_item_type;

endpackage

// ===== sv/central_difference_gradient_unit.sv =====
// Central difference gradient unit top: cdg_ctrl, cdg_grad and two cdg_ram line buffers.
// Depends on cdg_pkg.
// Accepted words pass through the stage register and the result register to rsp_valid; a pixel releases the result
// for the pixel one row above it, flush words drain the last row.
// Throughput: one word per cycle while req_stall is low; each line buffer has one read port and one write port.
// Reset: counters and handshake state clear, size returns to 640 x 480, line buffers kept.
module central_difference_gradient_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [cdg_pkg::PIXEL_W-1:0]       req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_x,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_y,
   output logic                              rsp_frame_end,
   input  logic                              csr_wr_en,
   input  logic [cdg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cdg_pkg::CSR_DATA_W-1:0]    csr_data
);

   import cdg_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);

   logic               accept;
   cdg_item_type       item;
   logic [XW-1:0]      col;
   logic [XW-1:0]      next_col;
   logic [PIXEL_W-1:0] cur_rdata;
   logic [PIXEL_W-1:0] above_rdata;
   logic               above_wr_en;
   logic [XW-1:0]      above_wr_addr;
   logic [PIXEL_W-1:0] above_wr_data;

   assign accept = req_valid && !req_stall;

   cdg_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .action    (req_action),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .item      (item),
      .col       (col),
      .next_col  (next_col)
   );

   // current line: written at the pixel's column, read one column ahead
   cdg_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_cur_line (
      .clock   (clock),
      .wr_en   (item.pix_write),
      .wr_addr (col),
      .wr_data (req_pixel),
      .rd_en   (item.active),
      .rd_addr (next_col),
      .rd_data (cur_rdata)
   );

   // line two rows back
   cdg_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_above_line (
      .clock   (clock),
      .wr_en   (above_wr_en),
      .wr_addr (above_wr_addr),
      .wr_data (above_wr_data),
      .rd_en   (item.active),
      .rd_addr (col),
      .rd_data (above_rdata)
   );

   cdg_grad #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_grad (
      .clock         (clock),
      .reset         (reset),
      .item          (item),
      .col           (col),
      .pixel         (req_pixel),
      .cur_rdata     (cur_rdata),
      .above_rdata   (above_rdata),
      .above_wr_en   (above_wr_en),
      .above_wr_addr (above_wr_addr),
      .above_wr_data (above_wr_data),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_grad_x    (rsp_grad_x),
      .rsp_grad_y    (rsp_grad_y),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== sv/cdg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for both line buffers.
module cdg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cdg_ctrl.sv =====
// Frame geometry registers and raster position counters.
// Depends on cdg_pkg and the assertion macro header.
`include "central_difference_gradient_unit_macros.svh"

module cdg_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int XW = $clog2(MAX_WIDTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              action,
   input  logic                              csr_wr_en,
   input  logic [cdg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cdg_pkg::CSR_DATA_W-1:0]    csr_data,
   output cdg_pkg::cdg_item_type             item,
   output logic [XW-1:0]                     col,
   output logic [XW-1:0]                     next_col
);

   import cdg_pkg::*;

   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int W_RST = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
   localparam int H_RST = (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RESET;

   // dimensions are kept as (size - 1), clamped to 1..MAX
   logic [XW-1:0] width_m1_ff, width_m1_in;
   logic [YW-1:0] height_m1_ff, height_m1_in;
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic          draining_ff, draining_in;
   logic [XW-1:0] csr_w_m1;
   logic [YW-1:0] csr_h_m1;
   logic          is_pix;

   always_comb begin
      if (csr_data == '0) begin
         csr_w_m1 = '0;
      end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
         csr_w_m1 = XW'(MAX_WIDTH - 1);
      end else begin
         csr_w_m1 = XW'(csr_data - CSR_DATA_W'(1));
      end
      if (csr_data == '0) begin
         csr_h_m1 = '0;
      end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
         csr_h_m1 = YW'(MAX_HEIGHT - 1);
      end else begin
         csr_h_m1 = YW'(csr_data - CSR_DATA_W'(1));
      end
   end

   always_comb begin
      is_pix          = (action == ACT_PIXEL);
      item.active     = accept && (is_pix ? !draining_ff : draining_ff);
      item.pix_write  = item.active && is_pix;
      item.has_result = item.active && (draining_ff || row_ff != '0);
      item.is_drain   = draining_ff;
      item.first_col  = (col_ff == '0);
      item.last_col   = (col_ff == width_m1_ff);
      item.w_one      = (width_m1_ff == '0);
      item.row_one    = (row_ff == YW'(1));
      item.h_one      = (height_m1_ff == '0);
   end

   assign col      = col_ff;
   assign next_col = item.last_col ? '0 : col_ff + XW'(1);

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      draining_in  = draining_ff;
      if (csr_wr_en) begin
         case (cdg_csr_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               width_m1_in = csr_w_m1;
               col_in      = '0;
               row_in      = '0;
               draining_in = 1'b0;
            end
            CSR_IMAGE_HEIGHT: begin
               height_m1_in = csr_h_m1;
               col_in       = '0;
               row_in       = '0;
               draining_in  = 1'b0;
            end
            default: begin
               col_in = col_ff;
            end
         endcase
      end else if (item.active) begin
         if (!item.last_col) begin
            col_in = next_col;
         end else if (item.is_drain) begin
            // last word of the frame
            col_in      = '0;
            row_in      = '0;
            draining_in = 1'b0;
         end else begin
            col_in = '0;
            if (row_ff == height_m1_ff) begin
               row_in      = '0;
               draining_in = 1'b1;
            end else begin
               row_in = row_ff + YW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= XW'(W_RST - 1);
         height_m1_ff <= YW'(H_RST - 1);
         col_ff       <= '0;
         row_ff       <= '0;
         draining_ff  <= 1'b0;
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         draining_ff  <= draining_in;
      end
   end

   `CDG_ASSERT_IMP(a_col_in_range, clock, reset, 1'b1, col_ff <= width_m1_ff, "column past row end")
   `CDG_ASSERT_IMP(a_drain_row_zero, clock, reset, draining_ff, row_ff == '0, "row set while draining")
   `CDG_ASSERT_NXT(a_drain_restart, clock, reset, item.active && item.is_drain && item.last_col && !csr_wr_en, !draining_ff && col_ff == '0, "frame not restarted after last drain word")

endmodule

// ===== sv/cdg_grad.sv =====
// Gradient datapath: tap registers, one compute stage and the result register.
// Depends on cdg_pkg and the assertion macro header.
`include "central_difference_gradient_unit_macros.svh"

module cdg_grad #(
   parameter int MAX_WIDTH = 1024,
   localparam int XW = $clog2(MAX_WIDTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cdg_pkg::cdg_item_type            item,
   input  logic [XW-1:0]                    col,
   input  logic [cdg_pkg::PIXEL_W-1:0]      pixel,
   input  logic [cdg_pkg::PIXEL_W-1:0]      cur_rdata,
   input  logic [cdg_pkg::PIXEL_W-1:0]      above_rdata,
   output logic                             above_wr_en,
   output logic [XW-1:0]                    above_wr_addr,
   output logic [cdg_pkg::PIXEL_W-1:0]      above_wr_data,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_x,
   output logic signed [cdg_pkg::GRAD_W-1:0] rsp_grad_y,
   output logic                             rsp_frame_end
);

   import cdg_pkg::*;

   function automatic cdg_grad_type diff(input logic [PIXEL_W-1:0] a,
                                         input logic [PIXEL_W-1:0] b);
      diff = GRAD_W'(a) - GRAD_W'(b);
   endfunction

   function automatic cdg_grad_type dbl(input cdg_grad_type d);
      dbl = {d[GRAD_W-2:0], 1'b0};
   endfunction

   logic               s1_valid_ff, s1_valid_in;
   cdg_item_type       s1_item_ff, s1_item_in;
   logic [XW-1:0]      s1_col_ff, s1_col_in;
   logic [PIXEL_W-1:0] s1_pixel_ff, s1_pixel_in;
   // previous-row taps: mid is the word read one step back, left two steps back
   logic [PIXEL_W-1:0] mid_ff, mid_in;
   logic [PIXEL_W-1:0] left_ff, left_in;
   // one-pixel-wide frames bypass the line buffers
   logic [PIXEL_W-1:0] pix_d1_ff, pix_d1_in;
   logic [PIXEL_W-1:0] pix_d2_ff, pix_d2_in;
   logic [PIXEL_W-1:0] s1_mid1_ff, s1_mid1_in;
   logic [PIXEL_W-1:0] s1_older1_ff, s1_older1_in;
   logic               out_valid_ff, out_valid_in;
   cdg_grad_type       out_gx_ff, out_gx_in;
   cdg_grad_type       out_gy_ff, out_gy_in;
   logic               out_end_ff, out_end_in;

   logic               out_ready;
   logic               s1_move;
   logic [PIXEL_W-1:0] mid;
   logic [PIXEL_W-1:0] older;
   cdg_grad_type       gx;
   cdg_grad_type       gy;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   always_comb begin
      mid   = s1_item_ff.w_one ? s1_mid1_ff : mid_ff;
      older = s1_item_ff.w_one ? s1_older1_ff : above_rdata;

      if (s1_item_ff.w_one) begin
         gx = '0;
      end else if (s1_item_ff.first_col) begin
         gx = dbl(diff(cur_rdata, mid));
      end else if (s1_item_ff.last_col) begin
         gx = dbl(diff(mid, left_ff));
      end else begin
         gx = diff(cur_rdata, left_ff);
      end

      if (s1_item_ff.is_drain) begin
         gy = s1_item_ff.h_one ? '0 : dbl(diff(mid, older));
      end else if (s1_item_ff.row_one) begin
         gy = dbl(diff(s1_pixel_ff, mid));
      end else begin
         gy = diff(s1_pixel_ff, older);
      end
   end

   // middle row moves into the older line while the stage holds a pixel word
   assign above_wr_en   = s1_valid_ff && !s1_item_ff.is_drain;
   assign above_wr_addr = s1_col_ff;
   assign above_wr_data = mid;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      s1_col_in    = s1_col_ff;
      s1_pixel_in  = s1_pixel_ff;
      mid_in       = mid_ff;
      left_in      = left_ff;
      pix_d1_in    = pix_d1_ff;
      pix_d2_in    = pix_d2_ff;
      s1_mid1_in   = s1_mid1_ff;
      s1_older1_in = s1_older1_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (item.active) begin
         s1_valid_in  = item.has_result;
         s1_item_in   = item;
         s1_col_in    = col;
         s1_pixel_in  = pixel;
         mid_in       = cur_rdata;
         left_in      = mid_ff;
         s1_mid1_in   = pix_d1_ff;
         s1_older1_in = pix_d2_ff;
      end
      if (item.pix_write) begin
         pix_d1_in = pixel;
         pix_d2_in = pix_d1_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_gx_in    = out_gx_ff;
      out_gy_in    = out_gy_ff;
      out_end_in   = out_end_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
         out_gx_in    = gx;
         out_gy_in    = gy;
         out_end_in   = s1_item_ff.is_drain && s1_item_ff.last_col;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff   <= s1_item_in;
      s1_col_ff    <= s1_col_in;
      s1_pixel_ff  <= s1_pixel_in;
      mid_ff       <= mid_in;
      left_ff      <= left_in;
      pix_d1_ff    <= pix_d1_in;
      pix_d2_ff    <= pix_d2_in;
      s1_mid1_ff   <= s1_mid1_in;
      s1_older1_ff <= s1_older1_in;
      out_gx_ff    <= out_gx_in;
      out_gy_ff    <= out_gy_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_grad_x    = out_gx_ff;
   assign rsp_grad_y    = out_gy_ff;
   assign rsp_frame_end = out_end_ff;

   `CDG_ASSERT_NXT(a_s1_fill, clock, reset, item.active && item.has_result, s1_valid_ff, "result word not staged")
   `CDG_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && out_valid_ff && rsp_stall, s1_valid_ff && $stable(s1_col_ff) && $stable(s1_pixel_ff), "staged word lost under stall")
   `CDG_ASSERT_NXT(a_s1_drain, clock, reset, s1_valid_ff && out_ready, rsp_valid, "staged word did not reach output")

endmodule

// ===== tb/central_difference_gradient_unit_test.sv =====
// Self-checking testbench for central_difference_gradient_unit: streams frames of pixels,
// predicts every gradient word and checks it against the block's output.
// Depends on cdg_pkg and the central_difference_gradient_unit RTL.
`timescale 1ns / 100ps

module central_difference_gradient_unit_test;
   import cdg_pkg::*;

   localparam int FRAME_MAX    = 1024;
   localparam int SETTLE       = 8;
   localparam int RANDOM_WORDS = 200;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      cdg_grad_type gx;
      cdg_grad_type gy;
      logic         fe;
   } grad_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   cdg_action_type        req_action = ACT_PIXEL;
   logic [PIXEL_W-1:0]    req_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   cdg_grad_type          rsp_grad_x;
   cdg_grad_type          rsp_grad_y;
   logic                  rsp_frame_end;
   logic                  csr_wr_en = 1'b0;
   cdg_csr_type           csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   central_difference_gradient_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_grad_x    (rsp_grad_x),
      .rsp_grad_y    (rsp_grad_y),
      .rsp_frame_end (rsp_frame_end),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [PIXEL_W-1:0]    line_above [FRAME_MAX];
   logic [PIXEL_W-1:0]    line_now   [FRAME_MAX];
   int                    col_pos, row_pos, drain_pos;
   bit                    in_drain;
   logic [CSR_DATA_W-1:0] cfg_width, cfg_height;

   grad_word_type expected_grads [$];
   int  error_count = 0;
   int  words_sent = 0;
   int  grads_checked = 0;
   int  frames_done = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  quiet = 1'b0;

   function automatic int eff_dim(input logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > FRAME_MAX) return FRAME_MAX;
      return int'(v);
   endfunction

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_grad(input int gx, input int gy, input bit fe);
      grad_word_type g;
      g.gx = cdg_grad_type'(gx);
      g.gy = cdg_grad_type'(gy);
      g.fe = fe;
      expected_grads.push_back(g);
   endtask

   task automatic predict_word(input cdg_action_type act, input logic [PIXEL_W-1:0] pix);
      int w, h, c, r, older, mid, gx, gy;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      if (act == ACT_PIXEL) begin
         if (!in_drain) begin
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = row_pos;
            if (r >= 1) begin
               older = int'(line_above[c]);
               mid = int'(line_now[c]);
               line_above[c] = line_now[c];
               if (w == 1)
                  gx = 0;
               else if (c == 0)
                  gx = 2 * (int'(line_now[1]) - mid);
               else if (c == w - 1)
                  gx = 2 * (mid - int'(line_above[c - 1]));
               else
                  gx = int'(line_now[c + 1]) - int'(line_above[c - 1]);
               gy = (r == 1) ? 2 * (int'(pix) - mid) : int'(pix) - older;
               push_grad(gx, gy, 1'b0);
            end
            line_now[c] = pix;
            if (c + 1 >= w) begin
               col_pos = 0;
               if (r + 1 >= h) begin
                  row_pos = 0;
                  drain_pos = 0;
                  in_drain = 1'b1;
               end else begin
                  row_pos = r + 1;
               end
            end else begin
               col_pos = c + 1;
            end
         end
      end else if (in_drain) begin
         c = (drain_pos >= w) ? w - 1 : drain_pos;
         mid = int'(line_now[c]);
         if (w == 1)
            gx = 0;
         else if (c == 0)
            gx = 2 * (int'(line_now[1]) - mid);
         else if (c == w - 1)
            gx = 2 * (mid - int'(line_now[c - 1]));
         else
            gx = int'(line_now[c + 1]) - int'(line_now[c - 1]);
         gy = (h == 1) ? 0 : 2 * (mid - int'(line_above[c]));
         push_grad(gx, gy, c + 1 >= w);
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = 0;
            drain_pos = 0;
            in_drain = 1'b0;
         end else begin
            drain_pos = c + 1;
         end
      end
   endtask

   // caller lowers req_valid (or sends again) in the step this returns
   task automatic send_word(input cdg_action_type act, input logic [PIXEL_W-1:0] pix);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_pixel  <= pix;
      do @(posedge clock); while (req_stall);
      predict_word(act, pix);
      words_sent++;
   endtask

   // always waits on the clock before returning, so the next send starts in a fresh step
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_grads.size() != 0);
   endtask

   task automatic wait_idle();
      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input cdg_csr_type idx, input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH)
         cfg_width = val;
      else
         cfg_height = val;
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
      in_drain = 1'b0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   // stop_at < 0: whole frame with drain; pause_at >= 0: hold off there until all results are in
   task automatic send_frame(input bit noisy, input int stop_at, input int pause_at);
      int w, h, n;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      for (n = 0; n < w * h && n != stop_at; n++) begin
         if (n == pause_at) hold_until_drained();
         send_word(ACT_PIXEL, rand_pixel());
         // stray flush inside the frame is ignored
         if (noisy && n < w * h - 1 && $urandom_range(0, 15) == 0)
            send_word(ACT_FLUSH, rand_pixel());
      end
      if (stop_at < 0) begin
         for (n = 0; n < w; n++) begin
            // stray pixel while draining is ignored
            if (noisy && $urandom_range(0, 7) == 0) send_word(ACT_PIXEL, rand_pixel());
            send_word(ACT_FLUSH, rand_pixel());
         end
      end
   endtask

   task automatic test_reset_geometry();
      int n;
      // frame is 640 wide after reset: a stray flush and first-row pixels give no word
      send_word(ACT_FLUSH, rand_pixel());
      for (n = 0; n < 24; n++) send_word(ACT_PIXEL, rand_pixel());
      wait_idle();
   endtask

   task automatic test_single_pixel_frame();
      set_geometry(0, 0);
      send_word(ACT_FLUSH, 8'hFF);
      send_word(ACT_PIXEL, 8'hFF);
      send_word(ACT_PIXEL, 8'h00);
      send_word(ACT_FLUSH, 8'h00);
      send_word(ACT_FLUSH, 8'hFF);
      send_word(ACT_PIXEL, 8'h00);
      send_word(ACT_FLUSH, 8'hA5);
      wait_idle();
   endtask

   task automatic test_small_frame();
      int n;
      set_geometry(3, 3);
      for (n = 0; n < 9; n++) send_word(ACT_PIXEL, (n % 2 == 0) ? 8'hFF : 8'h00);
      for (n = 0; n < 3; n++) send_word(ACT_FLUSH, 8'h00);
      set_geometry(1, 1);
      send_frame(1'b0, -1, -1);
      wait_idle();
   endtask

   task automatic test_thin_frames();
      set_geometry(1, 4);
      send_frame(1'b0, -1, -1);
      set_geometry(4, 1);
      send_frame(1'b0, -1, -1);
      set_geometry(2, 2);
      send_frame(1'b0, -1, -1);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int start, w, h, cut, pause, total;
      bit fresh, paused;
      start = words_sent;
      fresh = 1'b1;
      paused = 1'b0;
      while (words_sent - start < RANDOM_WORDS) begin
         if (fresh || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: w = 0;
               1: w = $urandom_range(13, 40);
               default: w = $urandom_range(1, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 1) == 0) begin
               set_geometry(CSR_DATA_W'(w), CSR_DATA_W'(h));
            end else begin
               write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
               write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
            end
         end
         fresh = 1'b0;
         if ($urandom_range(0, 3) == 0) send_word(ACT_FLUSH, rand_pixel());
         total = eff_dim(cfg_width) * eff_dim(cfg_height);
         cut = (total > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : -1;
         pause = -1;
         if (!paused && total > 4) begin
            pause = $urandom_range(2, total - 1);
            paused = 1'b1;
         end
         send_frame(1'b1, cut, pause);
         // a cut frame leaves the block mid-frame; restart it through the registers
         if (cut >= 0) fresh = 1'b1;
      end
      wait_idle();
   endtask

   task automatic test_steady_stream();
      quiet = 1'b1;
      set_geometry(9, 5);
      send_frame(1'b0, -1, -1);
      send_frame(1'b0, -1, -1);
      set_geometry(16, 3);
      send_frame(1'b0, -1, -1);
      wait_idle();
   endtask

   // result side: random stall bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      grad_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_grads.size() == 0) begin
            $error("unexpected word: grad_x %0d grad_y %0d frame_end %0b",
                   rsp_grad_x, rsp_grad_y, rsp_frame_end);
            error_count++;
         end else begin
            want = expected_grads.pop_front();
            if (rsp_grad_x !== want.gx) begin
               $error("grad_x: expected %0d, actual %0d", want.gx, rsp_grad_x);
               error_count++;
            end
            if (rsp_grad_y !== want.gy) begin
               $error("grad_y: expected %0d, actual %0d", want.gy, rsp_grad_y);
               error_count++;
            end
            if (rsp_frame_end !== want.fe) begin
               $error("frame_end: expected %0b, actual %0b", want.fe, rsp_frame_end);
               error_count++;
            end
            grads_checked++;
            if (want.fe) frames_done++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, expected_grads.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      cfg_width = CSR_DATA_W'(IMAGE_WIDTH_RESET);
      cfg_height = CSR_DATA_W'(IMAGE_HEIGHT_RESET);
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
      in_drain = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_single_pixel_frame();
      test_small_frame();
      test_thin_frames();
      test_random_frames();
      test_steady_stream();

      $display("Run sent %0d words and checked %0d gradient words over %0d frames,", words_sent,
               grads_checked, frames_done);
      $display("sizes 1x1 up to 40 wide and 6 tall, zero sizes, stray words, cut frames, stalls.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
